FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, gated by the active-low reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/xkf_pkg.sv
package xkf_pkg;

    localparam int BYTE_W      = 8;
    localparam int MASK_W      = 256;
    localparam int COL_IDX_W   = 5;
    localparam int KEY_LEN_W   = 6;
    localparam int S_TDATA_W   = 8;
    localparam int M_PAYLOAD_W = COL_IDX_W + MASK_W;
    localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_PAYLOAD_W;

    // allowed plaintext codes
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'd33;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'd34;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'd44;
    localparam logic [BYTE_W-1:0] CH_DASH   = 8'd45;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'd46;
    localparam logic [BYTE_W-1:0] CH_DIG_LO = 8'd48;
    localparam logic [BYTE_W-1:0] CH_DIG_HI = 8'd59;
    localparam logic [BYTE_W-1:0] CH_UC_LO  = 8'd65;
    localparam logic [BYTE_W-1:0] CH_UC_HI  = 8'd90;
    localparam logic [BYTE_W-1:0] CH_LC_LO  = 8'd97;
    localparam logic [BYTE_W-1:0] CH_LC_HI  = 8'd122;

    typedef logic [MASK_W-1:0] mask_t;

    function automatic logic char_allowed(input logic [BYTE_W-1:0] c);
        logic ok;
        ok = (c == CH_SPACE) || (c == CH_BANG) || (c == CH_QUOTE) ||
             (c == CH_COMMA) || (c == CH_DASH) || (c == CH_DOT) ||
             ((c >= CH_DIG_LO) && (c <= CH_DIG_HI)) ||
             ((c >= CH_UC_LO) && (c <= CH_UC_HI)) ||
             ((c >= CH_LC_LO) && (c <= CH_LC_HI));
        return ok;
    endfunction

    // bit k set when guess k maps byte b onto an allowed character
    function automatic mask_t keep_mask(input logic [BYTE_W-1:0] b);
        mask_t m;
        m = '0;
        for (int k = 0; k < MASK_W; k++)
        begin
            m[k] = char_allowed(BYTE_W'(k) ^ b);
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/xkf_mask_ram.sv
module xkf_mask_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [xkf_pkg::MASK_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [xkf_pkg::MASK_W-1:0] wr_data
);
    import xkf_pkg::*;

    mask_t mem [DEPTH];
    mask_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when idle; old data on a same-edge write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/xkf_col_update.sv
module xkf_col_update #(
    parameter int AW = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       upd_valid,
    input  logic [AW-1:0]              upd_col,
    input  logic [xkf_pkg::BYTE_W-1:0] upd_byte,
    input  logic                       entry_valid,
    input  logic [xkf_pkg::MASK_W-1:0] rd_data,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [xkf_pkg::MASK_W-1:0] wr_data
);
    import xkf_pkg::*;

    logic          fwd_en_reg;
    logic [AW-1:0] fwd_col_reg;
    mask_t         fwd_data_reg;
    mask_t         prior;
    mask_t         new_mask;
    logic          fwd_hit;

    // last write is not yet in the read data of the update that follows it
    assign fwd_hit  = fwd_en_reg && (fwd_col_reg == upd_col);
    assign prior    = fwd_hit ? fwd_data_reg : (entry_valid ? rd_data : '1);
    assign new_mask = prior & keep_mask(upd_byte);

    assign wr_en   = upd_valid;
    assign wr_addr = upd_col;
    assign wr_data = new_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_en_reg <= 1'b0;
        end
        else
        begin
            fwd_en_reg <= upd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_col_reg  <= upd_col;
        fwd_data_reg <= new_mask;
    end

endmodule

FILE: rtl/core/xor_key_byte_candidate_filter.sv
// Channel   Dir  Beat content
// s_*       in   tdata[7:0] cipher_byte, tlast end_of_text
// m_*       out  tdata[4:0] column_index, [260:5] candidates_0..3, tlast final_column
// cfg_*     in   cfg_data[5:0] key_length
//
// One byte per cycle while s_tready is high: a byte reads its column mask from the
// mask RAM on acceptance and writes back the ANDed mask on the next cycle; the last
// write is forwarded to a following byte of the same column.
// End of text: input stalls through the pending write-back, then the readout of
// L beats (L = effective key length), one column read per beat, plus any m_tready
// stalls; s_tready returns the cycle after the final beat is taken.
// Reset: masks read as all ones (per-column valid flops), position 0,
// key_length 1. No clearing pass; the valid flops are all cleared together.
module xor_key_byte_candidate_filter #(
    parameter int MAX_KEY_LEN = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // cfg_data: key_length
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [xkf_pkg::KEY_LEN_W-1:0] cfg_data,
    // s_tdata: cipher_byte
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [xkf_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    // m_tdata: column_index, candidates_0, candidates_1, candidates_2,
    //          candidates_3, zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [xkf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import xkf_pkg::*;

    localparam int PW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int LW = $clog2(MAX_KEY_LEN + 1);

    logic [KEY_LEN_W-1:0]   key_len_reg;
    logic [LW-1:0]          eff_len;
    logic [PW-1:0]          pos_reg;
    logic [PW-1:0]          pos_next;
    logic [LW-1:0]          pos_inc;
    logic [MAX_KEY_LEN-1:0] vld_reg;

    // write-back stage
    logic                   s1_valid_reg;
    logic [PW-1:0]          s1_col_reg;
    logic [BYTE_W-1:0]      s1_byte_reg;

    // readout
    logic                   busy_reg;
    logic [LW-1:0]          drain_cnt_reg;
    logic                   out_valid_reg;
    logic                   out_ent_vld_reg;
    logic [COL_IDX_W-1:0]   out_col_reg;
    logic                   out_last_reg;

    logic                   s_accept;
    logic                   m_accept;
    logic                   drain_issue;
    logic                   drain_done;

    logic                   rd_en;
    logic [PW-1:0]          rd_addr;
    mask_t                  rd_data;
    logic                   wr_en;
    logic [PW-1:0]          wr_addr;
    mask_t                  wr_data;

    // 0 acts as 1, values past the depth clamp to it
    always_comb
    begin
        priority if (key_len_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (32'(key_len_reg) > MAX_KEY_LEN)
        begin
            eff_len = LW'(MAX_KEY_LEN);
        end
        else
        begin
            eff_len = LW'(key_len_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;

    assign pos_inc  = LW'(pos_reg) + LW'(1);
    assign pos_next = (pos_inc >= eff_len) ? '0 : PW'(pos_inc);

    // wait while a write-back is pending so the last byte's write lands before column 0 is read
    assign drain_issue = busy_reg && !s1_valid_reg && (drain_cnt_reg < eff_len) &&
                         (!out_valid_reg || m_tready);
    assign drain_done  = drain_issue && ((drain_cnt_reg + LW'(1)) == eff_len);

    assign rd_en   = s_accept || drain_issue;
    assign rd_addr = busy_reg ? PW'(drain_cnt_reg) : pos_reg;

    xkf_mask_ram #(
        .DEPTH (MAX_KEY_LEN),
        .AW    (PW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    xkf_col_update #(
        .AW (PW)
    ) u_upd (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd_valid   (s1_valid_reg),
        .upd_col     (s1_col_reg),
        .upd_byte    (s1_byte_reg),
        .entry_valid (vld_reg[s1_col_reg]),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg     <= KEY_LEN_W'(1);
            pos_reg         <= '0;
            vld_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            busy_reg        <= 1'b0;
            drain_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                key_len_reg <= cfg_data;
            end

            s1_valid_reg <= s_accept;
            if (s_accept)
            begin
                pos_reg <= pos_next;
                if (s_tlast)
                begin
                    busy_reg <= 1'b1;
                end
            end

            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end

            if (drain_issue)
            begin
                drain_cnt_reg <= drain_cnt_reg + LW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (m_accept)
            begin
                out_valid_reg <= 1'b0;
            end

            // all beats read: masks back to ones for the next text
            if (drain_done)
            begin
                vld_reg <= '0;
                pos_reg <= '0;
            end

            if (m_accept && m_tlast)
            begin
                busy_reg      <= 1'b0;
                drain_cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_col_reg  <= pos_reg;
            s1_byte_reg <= s_tdata[BYTE_W-1:0];
        end
        if (drain_issue)
        begin
            out_ent_vld_reg <= vld_reg[PW'(drain_cnt_reg)];
            out_col_reg     <= COL_IDX_W'(drain_cnt_reg);
            out_last_reg    <= (drain_cnt_reg + LW'(1)) == eff_len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, (out_ent_vld_reg ? rd_data : {MASK_W{1'b1}}),
                       out_col_reg};

    `include "assert_macros.svh"

    // no byte enters while results are still going out
    `AST_IMPL(a_no_in_during_out, clk, rst_n, s_accept, !m_tvalid)
    // readout never competes with a pending write-back
    `AST_IMPL(a_drain_after_wb, clk, rst_n, drain_issue, !s1_valid_reg)
    // a taken non-final beat is followed by the next one at once
    `AST_NEXT(a_beats_dense, clk, rst_n, m_accept && !m_tlast, m_tvalid)
    // final beat releases the input side
    `AST_NEXT(a_release, clk, rst_n, m_accept && m_tlast, s_tready)

endmodule

FILE: dv/xor_key_byte_candidate_filter_test.sv
module xor_key_byte_candidate_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import xkf_pkg::*;

    localparam int MAX_COLS   = 32;
    localparam int SETTLE_CYC = 4;           // margin over the write-back stage
    localparam int N_PLAN     = 27;

    // One mask beat, m_tdata unpacked: column, four 64-bit slices, tlast.
    typedef struct packed {
        logic [COL_IDX_W-1:0] col;
        logic [63:0]          c0;
        logic [63:0]          c1;
        logic [63:0]          c2;
        logic [63:0]          c3;
        logic                 fin;
    } col_result_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    // Directed stimulus. A typed row carries its own mask for column 0 (key length 1).
    typedef struct packed {
        row_kind_t            kind;
        logic [KEY_LEN_W-1:0] len;
        logic [7:0]           b;
        logic                 last;
        logic                 typed;
        logic [63:0]          c0;
        logic [63:0]          c1;
        logic [63:0]          c2;
        logic [63:0]          c3;
    } plan_row_t;

    // Guess set for byte 0x00: the printable set itself.
    localparam logic [63:0] TXT_0  = 64'h0FFF_7007_0000_0000;
    localparam logic [63:0] TXT_1  = 64'h07FF_FFFE_07FF_FFFE;
    // Guess set for byte 0xFF: the same set, bit-reversed over 256.
    localparam logic [63:0] TXT_R1 = 64'h7FFF_FFE0_7FFF_FFE0;
    localparam logic [63:0] TXT_R0 = 64'h0000_0000_E00E_FFF0;
    localparam logic [63:0] Z64    = 64'd0;

    localparam plan_row_t PLAN [N_PLAN] = '{
        // key length 1 straight out of reset, both byte extremes
        '{ROW_BYTE, 6'd0,  8'h00, 1'b1, 1'b1, TXT_0, TXT_1, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'hFF, 1'b1, 1'b1, Z64, Z64, TXT_R1, TXT_R0},
        // zero length acts as one
        '{ROW_CFG,  6'd0,  8'h00, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h41, 1'b1, 1'b0, Z64, Z64, Z64, Z64},
        // three columns, column 0 gets two bytes, high byte in column 2
        '{ROW_CFG,  6'd3,  8'h00, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h20, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h7A, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h80, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h30, 1'b1, 1'b0, Z64, Z64, Z64, Z64},
        // text shorter than the key: empty columns report all ones
        '{ROW_CFG,  6'd5,  8'h00, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h55, 1'b1, 1'b0, Z64, Z64, Z64, Z64},
        // oversize lengths clamp to 32 columns
        '{ROW_CFG,  6'd63, 8'h00, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h01, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'hFE, 1'b1, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_CFG,  6'd33, 8'h00, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h7F, 1'b1, 1'b0, Z64, Z64, Z64, Z64},
        // length shrinks mid-text while the position sits past the new end
        '{ROW_CFG,  6'd4,  8'h00, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h10, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h22, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h33, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_CFG,  6'd2,  8'h00, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'hC3, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h9A, 1'b1, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_CFG,  6'd32, 8'h00, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'hAA, 1'b1, 1'b0, Z64, Z64, Z64, Z64},
        // back to one column: masks and position must be clean again
        '{ROW_CFG,  6'd1,  8'h00, 1'b0, 1'b0, Z64, Z64, Z64, Z64},
        '{ROW_BYTE, 6'd0,  8'h00, 1'b1, 1'b1, TXT_0, TXT_1, Z64, Z64}
    };

    localparam logic [7:0] PUNCT [6] = '{CH_SPACE, CH_BANG, CH_QUOTE, CH_COMMA, CH_DASH, CH_DOT};

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [KEY_LEN_W-1:0] cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Side band that travels with each byte beat: a typed mask replaces the predicted one.
    logic                 ovr_en    = 1'b0;
    col_result_t          ovr_val   = '0;

    int idle_pct  = 0;
    int stall_pct = 0;
    int fails     = 0;
    int n_bytes   = 0;
    int n_texts   = 0;
    int n_masks   = 0;
    int n_cfg     = 0;
    logic [KEY_LEN_W-1:0] cur_len = 6'd1;   // stimulus side copy of the register

    // Predictor state: register, column pointer, one 256-bit guess mask per column.
    logic [KEY_LEN_W-1:0] pred_len = 6'd1;
    int                   pred_pos = 0;
    logic [MASK_W-1:0]    pred_mask [MAX_COLS];
    col_result_t          pending_masks [$];

    xor_key_byte_candidate_filter #(
        .MAX_KEY_LEN (MAX_COLS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("xor_key_byte_candidate_filter: mismatch");
        $finish;
    end

    // 0 acts as 1, anything past 32 acts as 32
    function automatic int eff_of(input logic [KEY_LEN_W-1:0] len);
        int n;
        n = (len == 0) ? 1 : int'(len);
        return (n > MAX_COLS) ? MAX_COLS : n;
    endfunction

    function automatic logic is_text_char(input logic [7:0] c);
        case (c) inside
            CH_SPACE, CH_BANG, CH_QUOTE, CH_COMMA, CH_DASH, CH_DOT,
            [CH_DIG_LO:CH_DIG_HI], [CH_UC_LO:CH_UC_HI], [CH_LC_LO:CH_LC_HI]:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Narrow the column's guesses by one byte; on end of text queue one mask per column.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        logic [MASK_W-1:0] keep;
        col_result_t       r;
        int                len;
        int                col;
        len = eff_of(pred_len);
        col = pred_pos;
        for (int k = 0; k < MASK_W; k++)
        begin
            keep[k] = is_text_char(8'(k) ^ b);
        end
        pred_mask[col] &= keep;
        pred_pos = (col + 1 >= len) ? 0 : col + 1;
        if (last)
        begin
            for (int k = 0; k < len; k++)
            begin
                r.col = COL_IDX_W'(k);
                r.c0  = pred_mask[k][63:0];
                r.c1  = pred_mask[k][127:64];
                r.c2  = pred_mask[k][191:128];
                r.c3  = pred_mask[k][255:192];
                r.fin = (k == len - 1);
                pending_masks.push_back(r);
            end
            foreach (pred_mask[k])
            begin
                pred_mask[k] = '1;
            end
            pred_pos = 0;
        end
    endtask

    initial
    begin
        foreach (pred_mask[k])
        begin
            pred_mask[k] = '1;
        end
    end

    // Output side backpressure, redrawn every cycle.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // All handshakes are sampled here, on the values that the edge saw.
    always @(posedge clk)
    begin
        col_result_t got;
        col_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.col = m_tdata[COL_IDX_W-1:0];
                got.c0  = m_tdata[COL_IDX_W +: 64];
                got.c1  = m_tdata[COL_IDX_W + 64 +: 64];
                got.c2  = m_tdata[COL_IDX_W + 128 +: 64];
                got.c3  = m_tdata[COL_IDX_W + 192 +: 64];
                got.fin = m_tlast;
                if (pending_masks.size() == 0)
                begin
                    $error("mask beat with nothing pending, column_index %0d", got.col);
                    fails++;
                end
                else
                begin
                    want = pending_masks.pop_front();
                    n_masks++;
                    if (got.col !== want.col)
                    begin
                        $error("column_index: expected %0d, got %0d", want.col, got.col);
                        fails++;
                    end
                    if (got.c0 !== want.c0)
                    begin
                        $error("candidates_0: expected %h, got %h", want.c0, got.c0);
                        fails++;
                    end
                    if (got.c1 !== want.c1)
                    begin
                        $error("candidates_1: expected %h, got %h", want.c1, got.c1);
                        fails++;
                    end
                    if (got.c2 !== want.c2)
                    begin
                        $error("candidates_2: expected %h, got %h", want.c2, got.c2);
                        fails++;
                    end
                    if (got.c3 !== want.c3)
                    begin
                        $error("candidates_3: expected %h, got %h", want.c3, got.c3);
                        fails++;
                    end
                    if (got.fin !== want.fin)
                    begin
                        $error("final_column: expected %0d, got %0d", want.fin, got.fin);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                pred_len = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                absorb_byte(s_tdata, s_tlast);
                if (ovr_en)
                begin
                    pending_masks[pending_masks.size() - 1] = ovr_val;
                end
            end
        end
    end

    // Present one byte beat, after random idle cycles, and hold it until taken.
    task automatic put_byte(input logic [7:0] b, input logic last, input logic typed,
                            input col_result_t tv);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        ovr_en   <= typed;
        ovr_val  <= tv;
        do
            @(posedge clk);
        while (!s_tready);
        n_bytes++;
    endtask

    // Stop sending, let every pending mask drain, then cover the write-back tail.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_masks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_len(input logic [KEY_LEN_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_len = v;
        n_cfg++;
    endtask

    function automatic logic [KEY_LEN_W-1:0] draw_len();
        return ($urandom_range(3) == 0) ? KEY_LEN_W'($urandom_range(63))
                                        : KEY_LEN_W'($urandom_range(1, 8));
    endfunction

    // Mostly texts of printable characters under a random key, so guess masks
    // stay non-empty; the rest is raw noise or texts with a few corrupt bytes.
    task automatic random_texts(input int n_items);
        int         stop;
        int         tlen;
        int         eff;
        logic       clean;
        logic [7:0] key_bytes [MAX_COLS];
        logic [7:0] pt;
        logic [7:0] b;
        stop = n_bytes + n_items;
        while (n_bytes < stop)
        begin
            if ($urandom_range(2) == 0)
            begin
                write_len(draw_len());
            end
            eff   = eff_of(cur_len);
            tlen  = $urandom_range(1, 2 * eff + 3);
            clean = ($urandom_range(3) != 0);
            foreach (key_bytes[j])
            begin
                key_bytes[j] = 8'($urandom);
            end
            for (int p = 0; p < tlen; p++)
            begin
                case ($urandom_range(4))
                    0:       pt = PUNCT[$urandom_range(5)];
                    1:       pt = CH_DIG_LO + 8'($urandom_range(11));
                    2:       pt = CH_UC_LO + 8'($urandom_range(25));
                    3:       pt = CH_LC_LO + 8'($urandom_range(25));
                    default: pt = CH_SPACE;
                endcase
                if (clean && $urandom_range(19) != 0)
                begin
                    b = pt ^ key_bytes[p % eff];
                end
                else
                begin
                    b = 8'($urandom);
                end
                put_byte(b, (p == tlen - 1), 1'b0, '0);
                // occasional length change in the middle of a text
                if (p != tlen - 1 && $urandom_range(39) == 0)
                begin
                    write_len(draw_len());
                    eff = eff_of(cur_len);
                end
            end
            n_texts++;
            // sometimes hold off until every mask of the text is out
            if ($urandom_range(5) == 0)
            begin
                drain();
            end
        end
    endtask

    initial
    begin
        col_result_t tv;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_CFG)
            begin
                write_len(PLAN[i].len);
            end
            else
            begin
                tv = '{col: '0, c0: PLAN[i].c0, c1: PLAN[i].c1, c2: PLAN[i].c2,
                       c3: PLAN[i].c3, fin: 1'b1};
                put_byte(PLAN[i].b, PLAN[i].last, PLAN[i].typed, tv);
                if (PLAN[i].last)
                begin
                    n_texts++;
                end
            end
        end

        // free running, then sender gaps, then receiver stalls, then both
        idle_pct = 0;  stall_pct = 0;  random_texts(55);
        idle_pct = 60; stall_pct = 0;  random_texts(55);
        idle_pct = 0;  stall_pct = 60; random_texts(55);
        idle_pct = 18; stall_pct = 18; random_texts(55);

        drain();
        $display("covered %0d cipher bytes in %0d texts, %0d key length writes",
                 n_bytes, n_texts, n_cfg);
        $display("checked %0d column mask beats, %0d field errors", n_masks, fails);
        if (fails == 0)
        begin
            $display("xor_key_byte_candidate_filter: match");
        end
        else
        begin
            $display("xor_key_byte_candidate_filter: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/xkf_pkg.sv
rtl/core/xkf_mask_ram.sv
rtl/core/xkf_col_update.sv
rtl/core/xor_key_byte_candidate_filter.sv
dv/xor_key_byte_candidate_filter_test.sv
